FILE: rtl/core/serial_line_assembler_top_defines.svh
// Assertion macros shared by the serial line assembler RTL.
// Included by every file that carries concurrent assertions; no other dependencies.
`ifndef SERIAL_LINE_ASSEMBLER_TOP_DEFINES_SVH
`define SERIAL_LINE_ASSEMBLER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Check a property on an explicit clock, disabled while reset is low.
`define SLA_ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Check a property on the standard aclk / aresetn pair.
`define SLA_ASSERT(lbl, prop, msg) \
    `SLA_ASSERT_AT(lbl, aclk, aresetn, prop, msg)
`else
`define SLA_ASSERT_AT(lbl, clk, rstn, prop, msg)
`define SLA_ASSERT(lbl, prop, msg)
`endif
`endif

FILE: rtl/core/sla_pkg.sv
// Package for the serial line assembler: constants, command types, back-end states.
// No dependencies; imported by every module of the block but sla_ram.
`timescale 1ns / 1ps
package sla_pkg;
    localparam int LINE_ADDR_BITS_DEF = 5;
    localparam int SLOT_BITS_DEF      = 2;
    localparam int CMD_DEPTH_BITS     = 2;
    localparam int CHAR_W             = 8;

    localparam logic [CHAR_W-1:0] CHAR_CR = 8'd13;
    localparam logic [CHAR_W-1:0] CHAR_LF = 8'd10;

    typedef enum logic {
        CMD_STORE = 1'b0,
        CMD_FLUSH = 1'b1
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [CHAR_W-1:0] data;
    } sla_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef enum logic {
        B_IDLE   = 1'b0,
        B_STREAM = 1'b1
    } back_state_t;
endpackage

FILE: rtl/core/sla_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module sla_ram #(
    parameter int WIDTH      = 8,
    parameter int ADDR_BITS  = 5
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);
    localparam int DEPTH = 1 << ADDR_BITS;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

FILE: rtl/core/sla_front.sv
// Front end: accepts received bytes and classifies them into store / flush commands.
// Depends on sla_pkg.
`timescale 1ns / 1ps
module sla_front import sla_pkg::*; (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,
    input  fifo_status_t      fifo_status,
    output logic              push,
    output sla_cmd_t          push_cmd
);
    logic beat;

    assign s_tready = !fifo_status.full;
    assign beat     = s_tvalid && s_tready;

    // Drop carriage returns; line feed closes the line; everything else is stored.
    always_comb begin
        push_cmd.data = s_tdata;
        push_cmd.kind = (s_tdata == CHAR_LF) ? CMD_FLUSH : CMD_STORE;
        push          = beat && (s_tdata != CHAR_CR);
    end
endmodule

FILE: rtl/core/sla_cmd_fifo.sv
// Short command queue between the front end and the back end.
// Depends on sla_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "serial_line_assembler_top_defines.svh"
module sla_cmd_fifo import sla_pkg::*; #(
    parameter int DEPTH_BITS = CMD_DEPTH_BITS
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push,
    input  sla_cmd_t     push_cmd,
    input  logic         pop,
    output sla_cmd_t     head,
    output fifo_status_t status
);
    localparam int DEPTH = 1 << DEPTH_BITS;
    localparam logic [DEPTH_BITS:0] DEPTH_CNT = (DEPTH_BITS + 1)'(DEPTH);

    sla_cmd_t              buf_reg [DEPTH];
    logic [DEPTH_BITS-1:0] wptr_reg, wptr_next;
    logic [DEPTH_BITS-1:0] rptr_reg, rptr_next;
    logic [DEPTH_BITS:0]   count_reg, count_next;

    always_comb begin
        wptr_next  = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next  = pop  ? rptr_reg + 1'b1 : rptr_reg;
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wptr_reg] <= push_cmd;
        end
    end

    assign head         = buf_reg[rptr_reg];
    assign status.full  = (count_reg == DEPTH_CNT);
    assign status.empty = (count_reg == '0);

    `SLA_ASSERT(a_no_overflow, push |-> !status.full, "command queue overflow")
    `SLA_ASSERT(a_no_underflow, pop |-> !status.empty, "command queue underflow")
    `SLA_ASSERT(a_count_range, count_reg <= DEPTH_CNT, "command queue count out of range")
endmodule

FILE: rtl/core/sla_back.sv
// Back end: executes queued commands against the line store and streams finished lines.
// Depends on sla_pkg, sla_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "serial_line_assembler_top_defines.svh"
module sla_back import sla_pkg::*; #(
    parameter int LINE_ADDR_BITS = LINE_ADDR_BITS_DEF,
    parameter int SLOT_BITS      = SLOT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  fifo_status_t         fifo_status,
    input  sla_cmd_t             head,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [CHAR_W-1:0]    m_tdata,
    output logic [((SLOT_BITS > 0) ? SLOT_BITS : 1)-1:0] m_tuser,
    output logic                 m_tlast
);
    localparam int SLOT_W = (SLOT_BITS > 0) ? SLOT_BITS : 1;

    back_state_t               state_reg, state_next;
    logic [LINE_ADDR_BITS-1:0] len_reg, len_next;
    logic [LINE_ADDR_BITS-1:0] cnt_reg, cnt_next;
    logic [LINE_ADDR_BITS-1:0] idx_reg, idx_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic [SLOT_W-1:0]         cur_slot_reg, cur_slot_next;
    logic                      pend_reg, pend_next;
    logic                      pend_last_reg, pend_last_next;
    logic [SLOT_W-1:0]         pend_slot_reg, pend_slot_next;
    logic                      out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]         out_char_reg;
    logic [SLOT_W-1:0]         out_slot_reg;
    logic                      out_last_reg;

    logic                      load;
    logic                      issue;
    logic                      start;
    logic                      store;
    logic                      last_issue;
    logic [CHAR_W-1:0]         rdata;

    // Read data sits in the RAM output register until the output register frees.
    assign load       = pend_reg && (!out_valid_reg || m_tready);
    assign last_issue = (idx_reg == cnt_reg - 1'b1);

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE: begin
                if (!fifo_status.empty && head.kind == CMD_FLUSH && len_reg != '0) begin
                    state_next = B_STREAM;
                end
            end
            B_STREAM: begin
                if ((!pend_reg || load) && last_issue) begin
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    // Output decode.
    always_comb begin
        pop   = 1'b0;
        issue = 1'b0;
        case (state_reg)
            B_IDLE:   pop   = !fifo_status.empty;
            B_STREAM: issue = !pend_reg || load;
            default: begin
                pop   = 1'b0;
                issue = 1'b0;
            end
        endcase
    end

    assign store = pop && (head.kind == CMD_STORE);
    assign start = pop && (head.kind == CMD_FLUSH) && (len_reg != '0);

    always_comb begin
        len_next       = len_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        slot_next      = slot_reg;
        cur_slot_next  = cur_slot_reg;
        pend_next      = pend_reg;
        pend_last_next = pend_last_reg;
        pend_slot_next = pend_slot_reg;
        if (store) begin
            len_next = len_reg + 1'b1;
        end
        if (start) begin
            cnt_next      = len_reg;
            idx_next      = '0;
            len_next      = '0;
            cur_slot_next = slot_reg;
            slot_next     = (SLOT_BITS > 0) ? SLOT_W'(slot_reg + 1'b1) : '0;
        end
        if (load) begin
            pend_next = 1'b0;
        end
        if (issue) begin
            idx_next       = idx_reg + 1'b1;
            pend_next      = 1'b1;
            pend_last_next = last_issue;
            pend_slot_next = cur_slot_reg;
        end
        out_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            len_reg       <= '0;
            slot_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            slot_reg      <= slot_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        idx_reg       <= idx_next;
        cur_slot_reg  <= cur_slot_next;
        pend_last_reg <= pend_last_next;
        pend_slot_reg <= pend_slot_next;
        if (load) begin
            out_char_reg <= rdata;
            out_slot_reg <= pend_slot_reg;
            out_last_reg <= pend_last_reg;
        end
    end

    sla_ram #(
        .WIDTH     (CHAR_W),
        .ADDR_BITS (LINE_ADDR_BITS)
    ) u_line_store (
        .aclk  (aclk),
        .we    (store),
        .waddr (len_reg),
        .wdata (head.data),
        .re    (issue),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tuser  = out_slot_reg;
    assign m_tlast  = out_last_reg;

    `SLA_ASSERT(a_stream_nonempty, (state_reg == B_STREAM) |-> (cnt_reg != '0), "empty line streamed")
    `SLA_ASSERT(a_stream_len_clear, (state_reg == B_STREAM) |-> (len_reg == '0), "length kept while streaming")
    `SLA_ASSERT(a_pend_held, (pend_reg && !load) |=> pend_reg, "pending read byte lost")
    `SLA_ASSERT(a_no_pop_streaming, (state_reg == B_STREAM) |-> !pop, "command taken while streaming")
endmodule

FILE: rtl/core/serial_line_assembler_top.sv
// The first byte of a line reaches m_tvalid after its line feed's beat through the command queue,
// the back-end state register, the RAM read register and the output register; later bytes follow
// one per cycle while m_tready stays high. Throughput: one received byte per cycle into a 4-entry
// command queue while it is not full; the back end takes no command while it streams a line.
// Reset: aresetn synchronous, active low; clears length, slot number, queue and output valid.
// Top level of the serial line assembler.
// Depends on sla_pkg, sla_front, sla_cmd_fifo, sla_back (which holds sla_ram).
`timescale 1ns / 1ps
module serial_line_assembler_top import sla_pkg::*; #(
    parameter int LINE_ADDR_BITS = LINE_ADDR_BITS_DEF,
    parameter int SLOT_BITS      = SLOT_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // Received byte stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CHAR_W-1:0] s_tdata,   // [7:0] rx_byte
    // Line character stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [CHAR_W-1:0] m_tdata,   // [7:0] line_char
    output logic [((SLOT_BITS > 0) ? SLOT_BITS : 1)-1:0] m_tuser,  // slot
    output logic              m_tlast    // last character of the line
);
    // Front end classifies each beat; the queue decouples it from the streaming back end,
    // so bytes keep arriving, until the queue fills, while a finished line drains.
    fifo_status_t fifo_status;
    logic         push;
    sla_cmd_t     push_cmd;
    logic         pop;
    sla_cmd_t     head;

    sla_front u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .fifo_status (fifo_status),
        .push        (push),
        .push_cmd    (push_cmd)
    );

    sla_cmd_fifo #(
        .DEPTH_BITS (CMD_DEPTH_BITS)
    ) u_cmd_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (fifo_status)
    );

    // Back end owns the line store, the line length and the slot number; it streams
    // a finished line through a registered RAM read and an output register.
    sla_back #(
        .LINE_ADDR_BITS (LINE_ADDR_BITS),
        .SLOT_BITS      (SLOT_BITS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .fifo_status (fifo_status),
        .head        (head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );
endmodule

FILE: tb/serial_line_assembler_top_test.sv
// Self-checking testbench for serial_line_assembler_top: directed table, then random lines.
// Holds its own line predictor and beat scoreboard; depends on sla_pkg and the RTL only.
`timescale 1ns / 1ps
module serial_line_assembler_top_test;
    import sla_pkg::*;

    localparam int LINE_DEPTH = 1 << LINE_ADDR_BITS_DEF;
    localparam int SLOT_W     = (SLOT_BITS_DEF > 0) ? SLOT_BITS_DEF : 1;
    localparam int SLOT_COUNT = 1 << SLOT_BITS_DEF;
    localparam int RX_TARGET  = 470;
    localparam int SETTLE     = 40;       // longest line plus pipeline, in cycles
    localparam int CYCLE_CAP  = 600000;

    // One character of a finished line, as it should leave the block.
    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } line_beat_t;

    // Directed row: the byte to send and, where obvious, the typed outcome.
    // typed=1, one=0: no beat may result; typed=1, one=1: exactly one beat (last set).
    // typed=0: the predictor decides.
    typedef struct packed {
        logic [CHAR_W-1:0] rx;
        logic              typed;
        logic              one;
        logic [CHAR_W-1:0] ch;
        logic [SLOT_W-1:0] slot;
    } dir_row_t;

    localparam int N_DIR = 23;
    localparam dir_row_t DIR_ROWS [N_DIR] = '{
        '{CHAR_LF, 1'b1, 1'b0, 8'h00, 2'd0},   // empty line right after reset
        '{CHAR_CR, 1'b1, 1'b0, 8'h00, 2'd0},   // carriage return is dropped
        '{8'h00,   1'b1, 1'b0, 8'h00, 2'd0},   // zero byte is an ordinary character
        '{CHAR_LF, 1'b1, 1'b1, 8'h00, 2'd0},
        '{8'hFF,   1'b1, 1'b0, 8'h00, 2'd0},
        '{CHAR_CR, 1'b1, 1'b0, 8'h00, 2'd0},   // carriage return inside a line
        '{8'h41,   1'b1, 1'b0, 8'h00, 2'd0},
        '{CHAR_LF, 1'b0, 1'b0, 8'h00, 2'd0},
        '{CHAR_LF, 1'b1, 1'b0, 8'h00, 2'd0},   // empty line keeps the slot
        '{CHAR_CR, 1'b1, 1'b0, 8'h00, 2'd0},
        '{8'h80,   1'b1, 1'b0, 8'h00, 2'd0},
        '{CHAR_LF, 1'b1, 1'b1, 8'h80, 2'd2},
        '{8'h7F,   1'b1, 1'b0, 8'h00, 2'd0},
        '{CHAR_LF, 1'b1, 1'b1, 8'h7F, 2'd3},   // slot wraps to zero after this
        '{8'h0E,   1'b1, 1'b0, 8'h00, 2'd0},   // neighbors of the control codes
        '{8'h09,   1'b1, 1'b0, 8'h00, 2'd0},
        '{8'h0B,   1'b1, 1'b0, 8'h00, 2'd0},
        '{CHAR_LF, 1'b0, 1'b0, 8'h00, 2'd0},
        '{8'h55,   1'b1, 1'b0, 8'h00, 2'd0},
        '{8'hAA,   1'b1, 1'b0, 8'h00, 2'd0},
        '{CHAR_LF, 1'b0, 1'b0, 8'h00, 2'd0},
        '{8'h01,   1'b1, 1'b0, 8'h00, 2'd0},
        '{CHAR_LF, 1'b1, 1'b1, 8'h01, 2'd2}
    };

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [CHAR_W-1:0] s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [CHAR_W-1:0] m_tdata;
    logic [SLOT_W-1:0] m_tuser;
    logic              m_tlast;

    // Predictor state: line under construction and the slot of the next line.
    logic [CHAR_W-1:0] line_buf [LINE_DEPTH];
    int                line_len  = 0;
    int                slot_num  = 0;

    line_beat_t pending_beats [$];
    int         fail_count = 0;
    int         rx_count   = 0;
    int         burst_left = 0;
    int         cycle_count = 0;

    serial_line_assembler_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    // Advance the line predictor by one received byte; append any finished-line beats.
    function automatic void assemble_line(input logic [CHAR_W-1:0] b,
                                          ref line_beat_t beats [$]);
        line_beat_t beat;
        if (b == CHAR_CR)
            return;
        if (b == CHAR_LF) begin
            if (line_len == 0)
                return;
            for (int i = 0; i < line_len; i++) begin
                beat.ch   = line_buf[i];
                beat.slot = SLOT_W'(slot_num);
                beat.last = (i == line_len - 1);
                beats.push_back(beat);
            end
            line_len = 0;
            slot_num = (slot_num + 1) % SLOT_COUNT;
            return;
        end
        line_buf[line_len] = b;
        line_len = (line_len + 1) % LINE_DEPTH;
    endfunction

    // Any byte except line feed, so a line body never ends early.
    function automatic logic [CHAR_W-1:0] text_byte();
        logic [CHAR_W-1:0] b;
        do
            b = CHAR_W'($urandom_range(0, 255));
        while (b == CHAR_LF);
        return b;
    endfunction

    // Hold one beat on the input until accepted, then apply the sender's burst/gap pacing.
    task automatic put_rx_beat(input logic [CHAR_W-1:0] b);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge aclk);
        while (!s_tready);
        rx_count++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Predict and send one random-part byte; queue the expectation before the beat.
    task automatic send_predicted(input logic [CHAR_W-1:0] b);
        assemble_line(b, pending_beats);
        put_rx_beat(b);
    endtask

    // Drop valid and hold off until every expected beat has left, then let the block settle.
    task automatic drain_lines();
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Send one line: body of the given length, occasional carriage returns, then the end.
    task automatic send_line(input int body_len);
        for (int i = 0; i < body_len; i++) begin
            if ($urandom_range(0, 7) == 0)
                send_predicted(CHAR_CR);
            send_predicted(text_byte());
        end
        if ($urandom_range(0, 1) == 0)
            send_predicted(CHAR_CR);
        send_predicted(CHAR_LF);
    endtask

    // Receiver: switch stall pattern at random among always-ready, mostly-ready,
    // one-in-four and coin-flip.
    int unsigned stall_mode  = 0;
    int unsigned stall_phase = 0;
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1;
        if (stall_phase % 64 == 63)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            2: m_tready <= (stall_phase % 4 == 0);
            default: m_tready <= 1'($urandom_range(0, 1));
        endcase
    end

    // Scoreboard: compare each accepted output beat with the oldest expectation.
    always @(posedge aclk) begin
        line_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_beats.size() == 0) begin
                $error("unexpected beat: line_char=%0h slot=%0d last=%0b",
                       m_tdata, m_tuser, m_tlast);
                fail_count++;
            end else begin
                want = pending_beats.pop_front();
                if (m_tdata !== want.ch) begin
                    $error("line_char: expected %0h, got %0h", want.ch, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, m_tuser);
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_CAP) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        line_beat_t fresh [$];
        line_beat_t typed_beat;
        int         pick;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table: typed rows queue their own outcome, the rest the predictor's.
        for (int r = 0; r < N_DIR; r++) begin
            fresh.delete();
            assemble_line(DIR_ROWS[r].rx, fresh);
            if (DIR_ROWS[r].typed) begin
                if (DIR_ROWS[r].one) begin
                    typed_beat.ch   = DIR_ROWS[r].ch;
                    typed_beat.slot = DIR_ROWS[r].slot;
                    typed_beat.last = 1'b1;
                    pending_beats.push_back(typed_beat);
                end
            end else begin
                foreach (fresh[k])
                    pending_beats.push_back(fresh[k]);
            end
            put_rx_beat(DIR_ROWS[r].rx);
        end
        drain_lines();

        // Random lines: mostly short, some empty, overlong, exactly one or two wraps,
        // plus loose noise bytes.
        while (rx_count < RX_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_predicted(CHAR_W'($urandom_range(0, 255)));
            else if (pick < 14)
                send_line(0);
            else if (pick < 22)
                send_line($urandom_range(LINE_DEPTH - 1, 2 * LINE_DEPTH + 6));
            else if (pick < 26)
                send_line(($urandom_range(0, 1) == 0) ? LINE_DEPTH : 2 * LINE_DEPTH);
            else
                send_line($urandom_range(1, 12));
            // Hold off once midway until the output side has caught up.
            if (rx_count >= RX_TARGET / 2 && rx_count < RX_TARGET / 2 + 80 &&
                pending_beats.size() != 0 && $urandom_range(0, 3) == 0)
                drain_lines();
        end
        drain_lines();

        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
